### rtl/nsc_pkg.sv
// Package for the sentence checker: character codes, checksum modes, status codes,
// the end-of-sentence snapshot type and a hex digit decoder. No dependencies.
package nsc_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;

    localparam int unsigned CNT_W = 9;

    localparam logic [1:0] MODE_IGNORE   = 2'd0;
    localparam logic [1:0] MODE_VALIDATE = 2'd1;
    localparam logic [1:0] MODE_REQUIRE  = 2'd2;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_NO_DOLLAR  = 3'd2,
        ST_CKS_MISS   = 3'd3,
        ST_BAD_CKS    = 3'd4,
        ST_BAD_TALKER = 3'd5,
        ST_TOO_LONG   = 3'd6
    } t_status;

    typedef struct packed {
        logic             started;
        logic             dollar_first;
        logic             overflow;
        logic [23:0]      tail;
        logic [CNT_W-1:0] commas;
        logic [2:0]       comma_flags;
        logic [7:0]       xor_sum;
        logic             len_gt3;
        logic             six_stripped;
        logic             six_plain;
    } t_snap;

    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        begin
            r = 5'd0;
            if (c >= 8'h30 && c <= 8'h39) begin
                r = {1'b1, 4'(c - 8'h30)};
            end else if (c >= 8'h41 && c <= 8'h46) begin
                r = {1'b1, 4'(c - 8'h37)};
            end else if (c >= 8'h61 && c <= 8'h66) begin
                r = {1'b1, 4'(c - 8'h57)};
            end
            return r;
        end
    endfunction

endpackage

### rtl/nmea_sentence_checker_core.sv
// Top level of the NMEA 0183 sentence checker: input register, tracker, judge,
// result register and the checksum mode register. Uses nsc_pkg, nsc_track, nsc_judge.
//
//  channel  signals                                   direction
//  in       i_in_valid/o_in_ready, data_byte/last_byte  into block
//  out      o_out_valid/i_out_ready, six result fields   out of block
//  cfg      i_cfg_we, i_cfg_data (checksum mode)         into block
//
// One item per cycle while the output is not stalled.
// The tracker registers and the result register update in the same cycle.
// Reset clears sentence state and sets checksum mode to validate-if-present.
// A stalled output holds the result and, one item later, the input register.
module nmea_sentence_checker_core
    import nsc_pkg::*;
#(
    parameter int unsigned MAX_LENGTH = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_sentence_done,
    output logic [2:0]  o_status,
    output logic [7:0]  o_field_count,
    output logic        o_checksum_found,
    output logic [7:0]  o_computed_checksum,
    output logic [7:0]  o_running_field,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_data
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        r_out_valid;
    logic        r_done;
    t_status     r_status;
    logic [7:0]  r_field_count;
    logic        r_found;
    logic [7:0]  r_cks;
    logic [7:0]  r_run_field;
    logic [1:0]  r_mode;

    logic        out_free;
    logic        step;
    t_snap       snap;
    logic [7:0]  run_field;
    t_status     j_status;
    logic [7:0]  j_field_count;
    logic        j_found;
    logic [7:0]  j_cks;

    assign out_free   = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    nsc_track #(
        .MAX_LENGTH(MAX_LENGTH)
    ) u_track (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_data_byte    (r_in_byte),
        .i_last_byte    (r_in_last),
        .o_snap         (snap),
        .o_running_field(run_field)
    );

    nsc_judge u_judge (
        .i_snap             (snap),
        .i_mode             (r_mode),
        .o_status           (j_status),
        .o_field_count      (j_field_count),
        .o_checksum_found   (j_found),
        .o_computed_checksum(j_cks)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_VALIDATE;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_done      <= r_in_last;
            r_run_field <= run_field;
            if (r_in_last) begin
                r_status      <= j_status;
                r_field_count <= j_field_count;
                r_found       <= j_found;
                r_cks         <= j_cks;
            end else begin
                r_status      <= ST_OK;
                r_field_count <= 8'd0;
                r_found       <= 1'b0;
                r_cks         <= 8'd0;
            end
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_sentence_done     = r_done;
    assign o_status            = r_status;
    assign o_field_count       = r_field_count;
    assign o_checksum_found    = r_found;
    assign o_computed_checksum = r_cks;
    assign o_running_field     = r_run_field;

endmodule

### rtl/nsc_track.sv
// Per-sentence state tracker: trimming, running XOR, tail window, comma counts.
// Produces the end-of-sentence snapshot from next-state values. Uses nsc_pkg.
module nsc_track
    import nsc_pkg::*;
#(
    parameter int unsigned MAX_LENGTH = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output t_snap       o_snap,
    output logic [7:0]  o_running_field
);

    localparam int unsigned LW = $clog2(MAX_LENGTH + 3);
    localparam logic [LW-1:0] MAX_L  = LW'(MAX_LENGTH);
    localparam logic [LW-1:0] MAX_L1 = LW'(MAX_LENGTH + 1);

    logic             r_started, n_started;
    logic             r_dollar, n_dollar;
    logic [LW-1:0]    r_byte_count, n_byte_count;
    logic [LW-1:0]    r_trim_len, n_trim_len;
    logic [23:0]      r_tail, n_tail;
    logic [23:0]      r_tail_snap, n_tail_snap;
    logic             r_fc_valid, n_fc_valid;
    logic [LW-1:0]    r_fc_pos, n_fc_pos;
    logic [CNT_W-1:0] r_commas, n_commas;
    logic [2:0]       r_flags, n_flags;
    logic [CNT_W-1:0] r_commas_snap, n_commas_snap;
    logic [2:0]       r_flags_snap, n_flags_snap;
    logic [7:0]       r_xor, n_xor;
    logic             r_stopped, n_stopped;
    logic             r_overflow, n_overflow;
    logic [7:0]       r_ws_pend, n_ws_pend;

    logic             ws;
    logic             is_comma;
    logic             is_stop;
    logic [LW-1:0]    pos_inc;
    logic [LW-1:0]    slen_strip;
    logic [LW-1:0]    first_strip;
    logic [LW-1:0]    first_plain;

    assign ws = (i_data_byte == CH_SPACE) ||
                (i_data_byte >= CH_TAB && i_data_byte <= CH_CR);
    assign is_comma = (i_data_byte == CH_COMMA);
    assign is_stop  = (i_data_byte == CH_STAR) || (i_data_byte == CH_CR) ||
                      (i_data_byte == CH_LF);
    assign pos_inc  = r_byte_count + LW'(1);

    always_comb begin
        n_started     = r_started;
        n_dollar      = r_dollar;
        n_byte_count  = r_byte_count;
        n_trim_len    = r_trim_len;
        n_tail        = r_tail;
        n_tail_snap   = r_tail_snap;
        n_fc_valid    = r_fc_valid;
        n_fc_pos      = r_fc_pos;
        n_commas      = r_commas;
        n_flags       = r_flags;
        n_commas_snap = r_commas_snap;
        n_flags_snap  = r_flags_snap;
        n_xor         = r_xor;
        n_stopped     = r_stopped;
        n_overflow    = r_overflow;
        n_ws_pend     = r_ws_pend;
        if (!r_started && !ws) begin
            n_started = 1'b1;
            n_dollar  = (i_data_byte == CH_DOLLAR);
        end
        if (r_started || !ws) begin
            n_tail  = {r_tail[15:0], i_data_byte};
            n_flags = {r_flags[1:0], is_comma};
            if (is_comma) begin
                if (!r_fc_valid) begin
                    n_fc_valid = 1'b1;
                    n_fc_pos   = r_byte_count;
                end
                if (r_commas != {CNT_W{1'b1}}) begin
                    n_commas = r_commas + CNT_W'(1);
                end
            end
            if (r_started) begin
                if (!ws) begin
                    n_xor     = r_xor ^ r_ws_pend;
                    n_ws_pend = 8'd0;
                end
                if (is_stop) begin
                    n_stopped = 1'b1;
                end else if (!r_stopped) begin
                    if (ws) begin
                        n_ws_pend = r_ws_pend ^ i_data_byte;
                    end else begin
                        n_xor = n_xor ^ i_data_byte;
                    end
                end
            end
            if (!ws) begin
                n_trim_len    = pos_inc;
                n_tail_snap   = n_tail;
                n_commas_snap = n_commas;
                n_flags_snap  = n_flags;
                if (pos_inc > MAX_L) begin
                    n_overflow = 1'b1;
                end
            end
            n_byte_count = (pos_inc > MAX_L1) ? MAX_L1 : pos_inc;
        end
    end

    assign slen_strip  = n_trim_len - LW'(3);
    assign first_strip = (n_fc_valid && n_fc_pos < slen_strip) ? n_fc_pos : slen_strip;
    assign first_plain = (n_fc_valid && n_fc_pos < n_trim_len) ? n_fc_pos : n_trim_len;

    always_comb begin
        o_snap.started      = n_started;
        o_snap.dollar_first = n_dollar;
        o_snap.overflow     = n_overflow;
        o_snap.tail         = n_tail_snap;
        o_snap.commas       = n_commas_snap;
        o_snap.comma_flags  = n_flags_snap;
        o_snap.xor_sum      = n_xor;
        o_snap.len_gt3      = (n_trim_len > LW'(3));
        o_snap.six_stripped = (first_strip == LW'(6));
        o_snap.six_plain    = (first_plain == LW'(6));
    end

    assign o_running_field = (r_commas > CNT_W'(255)) ? 8'd255 : r_commas[7:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last_byte)) begin
            r_started     <= 1'b0;
            r_dollar      <= 1'b0;
            r_byte_count  <= '0;
            r_trim_len    <= '0;
            r_tail        <= '0;
            r_tail_snap   <= '0;
            r_fc_valid    <= 1'b0;
            r_fc_pos      <= '0;
            r_commas      <= '0;
            r_flags       <= '0;
            r_commas_snap <= '0;
            r_flags_snap  <= '0;
            r_xor         <= '0;
            r_stopped     <= 1'b0;
            r_overflow    <= 1'b0;
            r_ws_pend     <= '0;
        end else if (i_step) begin
            r_started     <= n_started;
            r_dollar      <= n_dollar;
            r_byte_count  <= n_byte_count;
            r_trim_len    <= n_trim_len;
            r_tail        <= n_tail;
            r_tail_snap   <= n_tail_snap;
            r_fc_valid    <= n_fc_valid;
            r_fc_pos      <= n_fc_pos;
            r_commas      <= n_commas;
            r_flags       <= n_flags;
            r_commas_snap <= n_commas_snap;
            r_flags_snap  <= n_flags_snap;
            r_xor         <= n_xor;
            r_stopped     <= n_stopped;
            r_overflow    <= n_overflow;
            r_ws_pend     <= n_ws_pend;
        end
    end

endmodule

### rtl/nsc_judge.sv
// End-of-sentence evaluation: checksum field decode, field count and status.
// Pure logic on the tracker snapshot. Uses nsc_pkg.
module nsc_judge
    import nsc_pkg::*;
(
    input  t_snap       i_snap,
    input  logic [1:0]  i_mode,
    output t_status     o_status,
    output logic [7:0]  o_field_count,
    output logic        o_checksum_found,
    output logic [7:0]  o_computed_checksum
);

    logic             stripped;
    logic [4:0]       hi;
    logic [4:0]       lo;
    logic             found;
    logic [7:0]       given;
    logic [1:0]       sub;
    logic [CNT_W:0]   fc_wide;
    logic             check_on;
    logic             first_six;

    assign stripped = i_snap.len_gt3 && (i_snap.tail[23:16] == CH_STAR);
    assign hi       = hex_decode(i_snap.tail[15:8]);
    assign lo       = hex_decode(i_snap.tail[7:0]);
    assign found    = stripped && hi[4] && lo[4];
    assign given    = {hi[3:0], lo[3:0]};
    assign sub      = stripped ? (2'(i_snap.comma_flags[0]) + 2'(i_snap.comma_flags[1])) : 2'd0;
    assign fc_wide  = {1'b0, i_snap.commas} - (CNT_W+1)'(sub) + (CNT_W+1)'(1);
    assign check_on = (i_mode == MODE_VALIDATE) || (i_mode == MODE_REQUIRE);
    assign first_six = stripped ? i_snap.six_stripped : i_snap.six_plain;

    always_comb begin
        o_status            = ST_OK;
        o_field_count       = 8'd0;
        o_checksum_found    = 1'b0;
        o_computed_checksum = 8'd0;
        if (!i_snap.started) begin
            o_status = ST_EMPTY;
        end else begin
            o_field_count       = (fc_wide > (CNT_W+1)'(255)) ? 8'd255 : fc_wide[7:0];
            o_checksum_found    = found;
            o_computed_checksum = i_snap.xor_sum;
            if (!i_snap.dollar_first) begin
                o_status = ST_NO_DOLLAR;
            end else if (i_snap.overflow) begin
                o_status = ST_TOO_LONG;
            end else if (i_mode == MODE_REQUIRE && !found) begin
                o_status = ST_CKS_MISS;
            end else if (found && check_on && i_snap.xor_sum != given) begin
                o_status = ST_BAD_CKS;
            end else if (!first_six) begin
                o_status = ST_BAD_TALKER;
            end
        end
    end

endmodule

### tb/sv/tb_nmea_sentence_checker_core.sv
// Self-checking testbench for nmea_sentence_checker_core: sends sentences one byte per item,
// predicts each result in its own scoreboard and compares it field by field; some directed
// rows fix their status. Depends on nsc_pkg and the RTL of nmea_sentence_checker_core.
module tb_nmea_sentence_checker_core;
    import nsc_pkg::*;

    localparam int unsigned MAX_LEN     = 255;
    localparam int unsigned NO_COMMA    = 32'hFFFF_FFFF;
    localparam int unsigned TALKER_LEN  = 6;
    localparam int unsigned CKS_TAIL    = 3;
    localparam int          PREDICTED   = -1;
    localparam int          N_DIR       = 22;
    localparam int          RAND_BYTES  = 240;
    localparam int          RAND_CHUNKS = 6;
    localparam int          HOLD_CYCLES = 60;
    localparam int          SETTLE      = 8;

    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [1:0] MODE_PLAN [RAND_CHUNKS] = '{
        MODE_REQUIRE, MODE_IGNORE, MODE_UNUSED, MODE_VALIDATE, MODE_REQUIRE, MODE_VALIDATE
    };

    typedef struct packed {
        logic       done;
        t_status    status;
        logic [7:0] field_count;
        logic       found;
        logic [7:0] cks;
        logic [7:0] run_field;
    } t_sentence_result;

    typedef struct {
        logic [1:0] mode;
        string      text;
        logic [7:0] fill_ch;
        int         fill_n;
        int         want;
    } t_dir_row;

    t_dir_row dir_rows [N_DIR] = '{
        '{MODE_VALIDATE, " \t\013\014\r\n",      CH_SPACE, 0,   ST_EMPTY},
        '{MODE_VALIDATE, "GPGGA,1",              CH_SPACE, 0,   ST_NO_DOLLAR},
        '{MODE_VALIDATE, "$GPGGA,1,2",           CH_SPACE, 0,   ST_OK},
        '{MODE_VALIDATE, "$GPGG,1",              CH_SPACE, 0,   ST_BAD_TALKER},
        '{MODE_VALIDATE, "$",                    CH_SPACE, 0,   ST_BAD_TALKER},
        '{MODE_VALIDATE, "$GPGGA,1*00",          CH_SPACE, 0,   ST_BAD_CKS},
        '{MODE_VALIDATE, "$GPGGA,1*4B\r\n",      CH_SPACE, 0,   ST_OK},
        '{MODE_VALIDATE, "\t $GPGGA,1*4b \r\n",  CH_SPACE, 0,   ST_OK},
        '{MODE_VALIDATE, "$GPGGA,1*4G",          CH_SPACE, 0,   PREDICTED},
        '{MODE_VALIDATE, "$GPGGA",               CH_SPACE, 0,   PREDICTED},
        '{MODE_VALIDATE, "$*4B",                 CH_SPACE, 0,   PREDICTED},
        '{MODE_VALIDATE, "$GPGGA,a,b*,,",        CH_SPACE, 0,   PREDICTED},
        '{MODE_VALIDATE, "$GPGGA,1\r,2*4B",      CH_SPACE, 0,   PREDICTED},
        '{MODE_VALIDATE, "$GPGGA 1, 2 ,3",       CH_SPACE, 0,   PREDICTED},
        '{MODE_VALIDATE, "$GPGGA,",              "A",      249, ST_TOO_LONG},
        '{MODE_REQUIRE,  "$GPGGA,1",             CH_SPACE, 0,   ST_CKS_MISS},
        '{MODE_REQUIRE,  "$GPGGA,1*4B",          CH_SPACE, 0,   ST_OK},
        '{MODE_REQUIRE,  "$GPGGA,1*00",          CH_SPACE, 0,   ST_BAD_CKS},
        '{MODE_IGNORE,   "$GPGGA,1*00",          CH_SPACE, 0,   ST_OK},
        '{MODE_IGNORE,   "$GPG,1",               CH_SPACE, 0,   ST_BAD_TALKER},
        '{MODE_UNUSED,   "$GPGGA,1*00",          CH_SPACE, 0,   ST_OK},
        '{MODE_UNUSED,   "$GPGGA,1",             CH_SPACE, 0,   ST_OK}
    };

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] in_data   = '0;
    logic       in_last   = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       res_done;
    logic [2:0] res_status;
    logic [7:0] res_fields;
    logic       res_found;
    logic [7:0] res_cks;
    logic [7:0] res_run;
    logic       cfg_we    = 1'b0;
    logic [1:0] cfg_data  = MODE_IGNORE;

    nmea_sentence_checker_core #(
        .MAX_LENGTH(MAX_LEN)
    ) i_dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_data_byte        (in_data),
        .i_last_byte        (in_last),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_sentence_done    (res_done),
        .o_status           (res_status),
        .o_field_count      (res_fields),
        .o_checksum_found   (res_found),
        .o_computed_checksum(res_cks),
        .o_running_field    (res_run),
        .i_cfg_we           (cfg_we),
        .i_cfg_data         (cfg_data)
    );

    always #6 clk = ~clk;

    logic [1:0]  cks_mode;
    logic        st_started, st_dollar, too_long, xor_halt;
    int unsigned byte_pos, trim_len, first_comma, n_commas, seen_commas;
    logic [23:0] tail_bytes, tail_seen;
    logic [2:0]  tail_commas, seen_flags;
    logic [7:0]  xor_acc, ws_xor;

    t_sentence_result results_due[$];
    logic [7:0]       sentence_buf[$];
    logic [6:0]       status_seen = '0;
    int n_fail = 0, n_checked = 0, n_bytes_sent = 0, n_sentences = 0;
    int tx_idle = 0, rx_idle = 0;
    int hold_asked = 0, hold_served = 0, hold_left = 0;

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic int hex_digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        return -1;
    endfunction

    function automatic void clear_sentence_state();
        st_started  = 1'b0;
        st_dollar   = 1'b0;
        too_long    = 1'b0;
        xor_halt    = 1'b0;
        byte_pos    = 0;
        trim_len    = 0;
        first_comma = NO_COMMA;
        n_commas    = 0;
        seen_commas = 0;
        tail_bytes  = '0;
        tail_seen   = '0;
        tail_commas = '0;
        seen_flags  = '0;
        xor_acc     = '0;
        ws_xor      = '0;
    endfunction

    function automatic t_sentence_result track_byte(input logic [7:0] b, input logic lst);
        t_sentence_result r;
        logic             blank, comma, stop, stripped, found;
        int unsigned      pos, slen, fields, first_len;
        int               h1, h2;
        logic [7:0]       given;
        blank       = is_blank(b);
        r           = '0;
        r.status    = ST_OK;
        r.run_field = (n_commas > 255) ? 8'd255 : 8'(n_commas);
        if (!st_started && !blank) begin
            st_started = 1'b1;
            st_dollar  = (b == CH_DOLLAR);
        end
        if (st_started) begin
            pos         = byte_pos;
            comma       = (b == CH_COMMA);
            stop        = (b == CH_STAR || b == CH_CR || b == CH_LF);
            tail_bytes  = {tail_bytes[15:0], b};
            tail_commas = {tail_commas[1:0], comma};
            if (comma) begin
                if (first_comma == NO_COMMA) first_comma = pos;
                if (n_commas < 16'hFFFF) n_commas++;
            end
            if (pos > 0) begin
                if (!blank) begin
                    xor_acc ^= ws_xor;
                    ws_xor = '0;
                end
                if (stop) begin
                    xor_halt = 1'b1;
                end else if (!xor_halt) begin
                    if (blank) ws_xor ^= b;
                    else xor_acc ^= b;
                end
            end
            if (!blank) begin
                trim_len    = pos + 1;
                tail_seen   = tail_bytes;
                seen_commas = n_commas;
                seen_flags  = tail_commas;
                if (pos + 1 > MAX_LEN) too_long = 1'b1;
            end
            byte_pos = (pos + 1 > MAX_LEN + 1) ? MAX_LEN + 1 : pos + 1;
        end
        if (!lst) return r;

        r.done = 1'b1;
        if (!st_started) begin
            r.status = ST_EMPTY;
        end else begin
            stripped = trim_len > CKS_TAIL && tail_seen[23:16] == CH_STAR;
            h1       = hex_digit_value(tail_seen[15:8]);
            h2       = hex_digit_value(tail_seen[7:0]);
            found    = stripped && h1 >= 0 && h2 >= 0;
            given    = found ? 8'(h1 * 16 + h2) : 8'd0;
            slen     = stripped ? trim_len - CKS_TAIL : trim_len;
            fields   = seen_commas;
            if (stripped) fields = fields - seen_flags[0] - seen_flags[1];
            fields++;
            first_len = (first_comma < slen) ? first_comma : slen;
            if (!st_dollar) begin
                r.status = ST_NO_DOLLAR;
            end else if (too_long) begin
                r.status = ST_TOO_LONG;
            end else if (cks_mode == MODE_REQUIRE && !found) begin
                r.status = ST_CKS_MISS;
            end else if (found && (cks_mode == MODE_VALIDATE || cks_mode == MODE_REQUIRE)
                         && xor_acc != given) begin
                r.status = ST_BAD_CKS;
            end else if (first_len != TALKER_LEN) begin
                r.status = ST_BAD_TALKER;
            end
            r.field_count = (fields > 255) ? 8'd255 : 8'(fields);
            r.found       = found;
            r.cks         = xor_acc;
        end
        clear_sentence_state();
        return r;
    endfunction

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            n_fail++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    function automatic void take_result();
        t_sentence_result want;
        if (results_due.size() == 0) begin
            n_fail++;
            $display("%0t: result with nothing pending, status %0d", $time, res_status);
            return;
        end
        want = results_due.pop_front();
        n_checked++;
        if (want.done) status_seen[want.status] = 1'b1;
        compare_field("sentence_done", want.done, res_done);
        compare_field("status", want.status, res_status);
        compare_field("field_count", want.field_count, res_fields);
        compare_field("checksum_found", want.found, res_found);
        compare_field("computed_checksum", want.cks, res_cks);
        compare_field("running_field", want.run_field, res_run);
    endfunction

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) take_result();
        if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES;
        end
        if (!rst_n || hold_left > 0) begin
            out_ready <= 1'b0;
            if (hold_left > 0) hold_left--;
        end else begin
            out_ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic lst, input int forced);
        t_sentence_result r;
        while ($urandom_range(99) < tx_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        in_last  <= lst;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        r = track_byte(b, lst);
        if (lst && forced != PREDICTED) r.status = t_status'(forced);
        results_due.push_back(r);
        n_bytes_sent++;
    endtask

    task automatic send_sentence(input int forced);
        foreach (sentence_buf[i]) push_byte(sentence_buf[i], i == sentence_buf.size() - 1, forced);
        n_sentences++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_mode(input logic [1:0] m);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cks_mode = m;
    endtask

    function automatic logic [7:0] blank_char();
        case ($urandom_range(5))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_LF;
            3: return CH_VT;
            4: return CH_FF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] text_char();
        logic [7:0] c;
        do c = 8'($urandom_range(8'h21, 8'h7E)); while (c == CH_STAR || c == CH_COMMA);
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 10) return "0" + 8'(v);
        return ($urandom_range(1) ? "A" : "a") + 8'(v) - 8'd10;
    endfunction

    function automatic void add_body(input logic [7:0] c, inout logic [7:0] sum);
        sentence_buf.push_back(c);
        sum ^= c;
    endfunction

    function automatic void build_sentence();
        int         kind, n;
        logic [7:0] sum;
        sentence_buf.delete();
        kind = $urandom_range(99);
        if (kind < 10) begin
            repeat ($urandom_range(1, 12)) sentence_buf.push_back(8'($urandom_range(255)));
            return;
        end
        if (kind < 14) begin
            repeat ($urandom_range(1, 4)) sentence_buf.push_back(blank_char());
            return;
        end
        sum = '0;
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 3)) sentence_buf.push_back(blank_char());
        end
        sentence_buf.push_back($urandom_range(19) == 0 ? text_char() : CH_DOLLAR);
        n = ($urandom_range(9) < 8) ? TALKER_LEN - 1 : $urandom_range(0, 9);
        repeat (n) add_body("A" + 8'($urandom_range(25)), sum);
        repeat ($urandom_range(0, 4)) begin
            add_body(CH_COMMA, sum);
            repeat ($urandom_range(0, 5)) add_body(text_char(), sum);
        end
        if ($urandom_range(59) == 0) begin
            add_body(CH_COMMA, sum);
            repeat ($urandom_range(230, 250)) add_body(text_char(), sum);
        end
        if ($urandom_range(14) == 0) begin
            sentence_buf.insert($urandom_range(1, sentence_buf.size() - 1),
                                8'($urandom_range(255)));
        end
        kind = $urandom_range(99);
        if (kind < 70) begin
            if ($urandom_range(9) == 0) sum ^= 8'(1 << $urandom_range(7));
            sentence_buf.push_back(CH_STAR);
            sentence_buf.push_back(hex_char(sum[7:4]));
            sentence_buf.push_back(hex_char(sum[3:0]));
        end else if (kind < 78) begin
            sentence_buf.push_back(CH_STAR);
            sentence_buf.push_back(text_char());
            sentence_buf.push_back(text_char());
        end else if (kind < 83) begin
            sentence_buf.push_back(CH_STAR);
            sentence_buf.push_back(hex_char(4'($urandom_range(15))));
        end
        if ($urandom_range(1)) begin
            sentence_buf.push_back(CH_CR);
            sentence_buf.push_back(CH_LF);
        end
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 3)) sentence_buf.push_back(blank_char());
        end
    endfunction

    initial begin
        int chunk_end;
        cks_mode = MODE_VALIDATE;
        clear_sentence_state();
        tx_idle = 38;
        rx_idle = 57;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].mode != cks_mode) write_mode(dir_rows[i].mode);
            sentence_buf.delete();
            for (int k = 0; k < dir_rows[i].text.len(); k++) begin
                sentence_buf.push_back(dir_rows[i].text[k]);
            end
            repeat (dir_rows[i].fill_n) sentence_buf.push_back(dir_rows[i].fill_ch);
            send_sentence(dir_rows[i].want);
        end

        for (int ch = 0; ch < RAND_CHUNKS; ch++) begin
            case (ch / 2)
                0: begin
                    tx_idle = 38;
                    rx_idle = 57;
                end
                1: begin
                    tx_idle = 57;
                    rx_idle = 38;
                end
                default: begin
                    tx_idle = 0;
                    rx_idle = 0;
                end
            endcase
            write_mode(MODE_PLAN[ch]);
            if (ch == RAND_CHUNKS - 2) hold_asked++;
            chunk_end = n_bytes_sent + RAND_BYTES / RAND_CHUNKS;
            while (n_bytes_sent < chunk_end) begin
                build_sentence();
                send_sentence(PREDICTED);
            end
        end

        drain();
        $display("Ran %0d sentences, %0d bytes, %0d results compared over all checksum modes,",
                 n_sentences, n_bytes_sent, n_checked);
        $display("with stalls on both sides and one long output hold; status codes hit: %b",
                 status_seen);
        if (n_fail == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #(12 * 400_000);
        $display("Timeout with %0d results still pending", results_due.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

### nmea_sentence_checker_core.f
rtl/nsc_pkg.sv
rtl/nsc_track.sv
rtl/nsc_judge.sv
rtl/nmea_sentence_checker_core.sv
tb/sv/tb_nmea_sentence_checker_core.sv
